FILE: hdl/bb3_pkg.sv
`default_nettype none

package bb3_pkg;

    // Default line store depth (pixels per row)
    localparam int MAX_WIDTH_DEF = 1024;

    // Configuration register widths and reset values
    localparam int WIDTH_W      = 11;
    localparam int HEIGHT_W     = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // Request modes
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // Divide by 9: floor(s / 9) == (s * 3641) >> 15 for every 3x3 sum of bytes
    localparam int SUM_W       = 12;
    localparam int PROD_W      = 24;
    localparam int RECIP_SHIFT = 15;
    localparam logic [SUM_W-1:0] RECIP_9 = 12'd3641;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
    } t_sum;

    // Input request
    typedef struct packed {
        logic       mode;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_in_req;

    // Output request
    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } t_out_req;

    // Window stage to averaging stage
    typedef struct packed {
        logic   interior;
        t_sum   sums;
        t_pixel pass_pix;
        logic   frame_end;
    } t_mean_req;

    function automatic logic [7:0] div9(input logic [SUM_W-1:0] s);
        logic [PROD_W-1:0] p;
        p = PROD_W'(s) * PROD_W'(RECIP_9);
        return p[RECIP_SHIFT +: 8];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/box_blur_3x3_rgb_core.sv
`default_nettype none

// 3x3 box blur on an RGB raster stream. One request is taken per clock, pixel or
// flush alike, unless back-pressure from the output stalls the input; each line
// store is read at most once and written at most once per clock, which sets that
// rate. A pixel request returns the output pixel lying width+1 pixels behind it
// in raster order (none for the first width+1 pixels of a frame); that result is
// registered in the window stage, the averaging stage and the output register in
// turn. Interior pixels leave as the per-channel floor of the 3x3 sum over 9;
// border pixels, and all pixels of a frame narrower or shorter than 3, pass
// through. After the last pixel of a frame, each flush request returns one of the
// width+1 held-back pixels, the final one marked frame_end; a flush at any other
// time, or with nothing held back, returns nothing. A width of 0 acts as 1 and a
// width above MAX_WIDTH as MAX_WIDTH; a height of 0 acts as 1. Writing either
// register restarts the frame. The line stores need no clearing after reset.
module box_blur_3x3_rgb_core #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // input channel
    input  wire                                i_valid,
    output logic                               o_stall,
    input  bb3_pkg::t_in_req                   i_data,
    // output channel
    output logic                               o_valid,
    input  wire                                i_stall,
    output bb3_pkg::t_out_req                  o_data,
    // configuration
    input  wire                                i_cfg_we,
    input  wire  [bb3_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [bb3_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WEF_W  = $clog2(MAX_WIDTH + 1);
    localparam int PEND_W = $clog2(MAX_WIDTH + 2);
    localparam int EXT_W  = (WEF_W > bb3_pkg::WIDTH_W) ? WEF_W : bb3_pkg::WIDTH_W;
    localparam int ROW_W  = bb3_pkg::HEIGHT_W;
    localparam int SUM_W  = bb3_pkg::SUM_W;

    // Frame position and configuration
    logic [bb3_pkg::WIDTH_W-1:0]  r_width;
    logic [bb3_pkg::HEIGHT_W-1:0] r_height;
    logic [COL_W-1:0]             r_col;
    logic [ROW_W-1:0]             r_row;
    logic [PEND_W-1:0]            r_pend;

    logic [EXT_W-1:0]  width_ext;
    logic [EXT_W-1:0]  w_eff_ext;
    logic [WEF_W-1:0]  w_eff;
    logic [WEF_W-1:0]  w_m1;
    logic [COL_W-1:0]  col_last;
    logic [ROW_W-1:0]  h_eff;
    logic [ROW_W-1:0]  row_last;

    // Request decode
    logic              accept;
    logic              is_pixel;
    logic              at_origin;
    logic              flush_go;
    logic              has_out;
    logic              interior;
    logic              pend_over;
    logic [PEND_W-1:0] pend_gap;
    logic [COL_W-1:0]  flush_addr;
    logic [COL_W-1:0]  rd_addr;

    // Window stage
    logic              r_s1_valid;
    logic              r_s1_pix;
    logic              r_s1_out;
    logic              r_s1_interior;
    logic              r_s1_sel_upper;
    logic              r_s1_frame_end;
    logic [COL_W-1:0]  r_s1_addr;
    bb3_pkg::t_pixel   r_s1_pixel;
    logic              r_fwd;
    bb3_pkg::t_pixel   r_fwd_upper;
    bb3_pkg::t_pixel   r_fwd_middle;
    bb3_pkg::t_pixel   r_rd_upper;
    bb3_pkg::t_pixel   r_rd_middle;
    bb3_pkg::t_pixel   cur_up;
    bb3_pkg::t_pixel   cur_mid;
    bb3_pkg::t_pixel   r_win [6];
    bb3_pkg::t_pixel   nbr [9];
    bb3_pkg::t_sum     sums;
    logic              s1_move;
    logic              s1_write;
    logic              s2_ready;
    bb3_pkg::t_mean_req mean_req;

    // Line stores
    bb3_pkg::t_pixel   mem_upper  [MAX_WIDTH];
    bb3_pkg::t_pixel   mem_middle [MAX_WIDTH];

    // Effective frame size
    always_comb begin
        width_ext = EXT_W'(r_width);
        if (r_width == '0) begin
            w_eff_ext = EXT_W'(1);
        end else if (width_ext > EXT_W'(MAX_WIDTH)) begin
            w_eff_ext = EXT_W'(MAX_WIDTH);
        end else begin
            w_eff_ext = width_ext;
        end
        w_eff    = w_eff_ext[WEF_W-1:0];
        w_m1     = w_eff - WEF_W'(1);
        col_last = w_m1[COL_W-1:0];
        h_eff    = (r_height == '0) ? ROW_W'(1) : r_height;
        row_last = h_eff - ROW_W'(1);
    end

    // Request decode at the current position
    always_comb begin
        accept    = i_valid && !o_stall;
        is_pixel  = (i_data.mode == bb3_pkg::MODE_PIXEL);
        at_origin = (r_col == '0) && (r_row == '0);
        flush_go  = !is_pixel && at_origin && (r_pend != '0);
        // output exists once width+1 pixels are in
        has_out   = (r_row >= ROW_W'(2)) || ((r_row == ROW_W'(1)) && (r_col != '0));
        interior  = (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));
        // held-back pixels: last of next-to-last row, then the whole last row
        pend_over = (r_pend > PEND_W'(w_eff));
        pend_gap  = PEND_W'(w_eff) - r_pend;
        flush_addr = pend_over ? col_last : pend_gap[COL_W-1:0];
        rd_addr    = is_pixel ? r_col : flush_addr;
    end

    // Configuration and frame position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bb3_pkg::WIDTH_W'(bb3_pkg::WIDTH_RESET);
            r_height <= bb3_pkg::HEIGHT_W'(bb3_pkg::HEIGHT_RESET);
            r_col    <= '0;
            r_row    <= '0;
            r_pend   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bb3_pkg::CFG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_data[bb3_pkg::WIDTH_W-1:0];
                end
                bb3_pkg::CFG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_data[bb3_pkg::HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
            r_col  <= '0;
            r_row  <= '0;
            r_pend <= '0;
        end else if (accept) begin
            if (is_pixel) begin
                if (r_col == col_last) begin
                    r_col <= '0;
                    r_row <= (r_row == row_last) ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
                if (at_origin) begin
                    r_pend <= PEND_W'(1);
                end else if (!has_out) begin
                    r_pend <= r_pend + PEND_W'(1);
                end
            end else if (flush_go) begin
                r_pend <= r_pend - PEND_W'(1);
            end
        end
    end

    // Stage handshake
    assign s1_move  = r_s1_valid && (s2_ready || !r_s1_out);
    assign s1_write = s1_move && r_s1_pix;
    assign o_stall  = r_s1_valid && !s1_move;

    // Stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= is_pixel || flush_go;
                r_fwd      <= s1_write && (r_s1_addr == rd_addr);
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Stage payload and forwarded write data
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix       <= is_pixel;
            r_s1_out       <= is_pixel ? has_out : 1'b1;
            r_s1_interior  <= is_pixel && interior;
            r_s1_sel_upper <= pend_over;
            r_s1_frame_end <= !is_pixel && (r_pend == PEND_W'(1));
            r_s1_addr      <= rd_addr;
            r_s1_pixel     <= '{red: i_data.in_red, green: i_data.in_green,
                                blue: i_data.in_blue};
            r_fwd_upper    <= cur_mid;
            r_fwd_middle   <= r_s1_pixel;
        end
    end

    // Line stores: read on accept, write back when the window stage retires
    always_ff @(posedge i_clk) begin
        if (s1_write) begin
            mem_upper[r_s1_addr]  <= cur_mid;
            mem_middle[r_s1_addr] <= r_s1_pixel;
        end
        if (accept) begin
            r_rd_upper  <= mem_upper[rd_addr];
            r_rd_middle <= mem_middle[rd_addr];
        end
    end

    // Column above the current pixel, bypassing a same-column write in flight
    assign cur_up  = r_fwd ? r_fwd_upper  : r_rd_upper;
    assign cur_mid = r_fwd ? r_fwd_middle : r_rd_middle;

    // Window shift
    always_ff @(posedge i_clk) begin
        if (s1_write) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= cur_up;
            r_win[4] <= cur_mid;
            r_win[5] <= r_s1_pixel;
        end
    end

    // 3x3 channel sums
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            nbr[k] = r_win[k];
        end
        nbr[6] = cur_up;
        nbr[7] = cur_mid;
        nbr[8] = r_s1_pixel;
        sums = '0;
        for (int k = 0; k < 9; k++) begin
            sums.sum_red   = sums.sum_red   + SUM_W'(nbr[k].red);
            sums.sum_green = sums.sum_green + SUM_W'(nbr[k].green);
            sums.sum_blue  = sums.sum_blue  + SUM_W'(nbr[k].blue);
        end
    end

    // Request to the averaging stage
    always_comb begin
        mean_req.interior  = r_s1_interior;
        mean_req.sums      = sums;
        mean_req.frame_end = r_s1_frame_end;
        if (r_s1_pix) begin
            // pixel one row up and one step back in raster order: middle row of
            // the previous column, also across a row wrap
            mean_req.pass_pix = r_win[4];
        end else begin
            mean_req.pass_pix = r_s1_sel_upper ? cur_up : cur_mid;
        end
    end

    bb3_mean_stage u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid && r_s1_out),
        .o_ready (s2_ready),
        .i_mean  (mean_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire

FILE: hdl/bb3_mean_stage.sv
`default_nettype none

module bb3_mean_stage (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  bb3_pkg::t_mean_req i_mean,
    output logic               o_valid,
    input  wire                i_stall,
    output bb3_pkg::t_out_req  o_data
);

    logic               r_s2_valid;
    bb3_pkg::t_mean_req r_s2;
    logic               r_o_valid;
    bb3_pkg::t_out_req  r_o;
    bb3_pkg::t_out_req  n_o;
    logic               out_free;

    // Output slot frees when empty or taken this cycle
    assign out_free = !r_o_valid || !i_stall;
    assign o_ready  = !r_s2_valid || out_free;

    // Mean per channel, or the passed-through pixel
    always_comb begin
        if (r_s2.interior) begin
            n_o.out_red   = bb3_pkg::div9(r_s2.sums.sum_red);
            n_o.out_green = bb3_pkg::div9(r_s2.sums.sum_green);
            n_o.out_blue  = bb3_pkg::div9(r_s2.sums.sum_blue);
        end else begin
            n_o.out_red   = r_s2.pass_pix.red;
            n_o.out_green = r_s2.pass_pix.green;
            n_o.out_blue  = r_s2.pass_pix.blue;
        end
        n_o.frame_end = r_s2.frame_end;
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s2_valid <= i_valid;
            end
            if (out_free) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s2 <= i_mean;
        end
        if (out_free && r_s2_valid) begin
            r_o <= n_o;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o;

endmodule

`default_nettype wire

FILE: tb/sv/box_blur_3x3_rgb_core_tb.sv
`timescale 1ns / 100ps

module box_blur_3x3_rgb_core_tb;

    localparam int MAX_W       = bb3_pkg::MAX_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 500_000;
    localparam int HOLD_CYCLES = 400;

    logic i_clk;
    logic rst_n = 1'b0;

    // input channel
    logic             in_valid = 1'b0;
    bb3_pkg::t_in_req in_req   = '0;
    logic             blk_stall;

    // output channel
    logic              res_valid;
    logic              res_stall = 1'b0;
    bb3_pkg::t_out_req res_data;

    // configuration port
    logic                           cfg_we    = 1'b0;
    logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // requests waiting to be sent, output pixels waiting to be seen
    bb3_pkg::t_in_req  stream_reqs[$];
    bb3_pkg::t_out_req expected_pixels[$];
    bb3_pkg::t_out_req want;

    // blur predictor state
    logic [bb3_pkg::WIDTH_W-1:0]  cfg_width  = bb3_pkg::WIDTH_W'(bb3_pkg::WIDTH_RESET);
    logic [bb3_pkg::HEIGHT_W-1:0] cfg_height = bb3_pkg::HEIGHT_W'(bb3_pkg::HEIGHT_RESET);
    bit [23:0]           line_top [MAX_W];
    bit [23:0]           line_mid [MAX_W];
    bit [23:0]           win_cols [6];
    int unsigned         pos_col   = 0;
    int unsigned         pos_row   = 0;
    int unsigned         held_back = 0;

    // stimulus generator view of the frame
    int unsigned frame_w;
    int unsigned frame_h;
    int unsigned gen_pos;

    // flow control
    bit calm    = 1'b0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int send_gap  = 0;
    int recv_gap  = 0;
    int hold_left = 0;
    int bad_count = 0;
    int cycle_count = 0;

    box_blur_3x3_rgb_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (blk_stall),
        .i_data      (in_req),
        .o_valid     (res_valid),
        .i_stall     (res_stall),
        .o_data      (res_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // width register as the block sees it: 0 acts as 1, clamp at the line store size
    function automatic int unsigned eff_width(input logic [bb3_pkg::WIDTH_W-1:0] w);
        if (w == '0) return 1;
        if (32'(w) > MAX_W) return MAX_W;
        return 32'(w);
    endfunction

    // advance the blur predictor by one accepted request
    task automatic blur_predict(input bb3_pkg::t_in_req req);
        int unsigned w, h, total, x, y, i, j, ox, oy, k;
        int unsigned sum_r, sum_g, sum_b;
        bit [23:0] pix, res_pix, v;
        bit [23:0] cur [3];
        bit emit;
        bb3_pkg::t_out_req res;
        w = eff_width(cfg_width);
        h = (cfg_height == '0) ? 1 : 32'(cfg_height);
        total = w * h;
        x = pos_col % w;
        y = pos_row % h;
        emit = 1'b0;
        j = 0;
        res_pix = '0;
        if (req.mode == bb3_pkg::MODE_FLUSH) begin
            // drains only between frames, and only what is held back
            if (x == 0 && y == 0 && held_back != 0) begin
                if (held_back > total) held_back = total;
                j = total - held_back;
                res_pix = (j >= total - w) ? line_mid[j % w] : line_top[j % w];
                held_back--;
                emit = 1'b1;
            end
        end else begin
            pix = {req.in_red, req.in_green, req.in_blue};
            cur[0] = line_top[x];
            cur[1] = line_mid[x];
            cur[2] = pix;
            i = y * w + x;
            // first pixel of a frame drops leftovers from the last one
            if (i == 0) held_back = 0;
            if (i >= w + 1) begin
                j = i - w - 1;
                oy = j / w;
                ox = j % w;
                if (w >= 3 && h >= 3 && oy >= 1 && oy <= h - 2 && ox >= 1 && ox <= w - 2) begin
                    sum_r = 0;
                    sum_g = 0;
                    sum_b = 0;
                    for (k = 0; k < 9; k++) begin
                        v = (k < 6) ? win_cols[k] : cur[k - 6];
                        sum_r += 32'(v[23:16]);
                        sum_g += 32'(v[15:8]);
                        sum_b += 32'(v[7:0]);
                    end
                    res_pix = {8'(sum_r / 9), 8'(sum_g / 9), 8'(sum_b / 9)};
                end else begin
                    res_pix = line_top[ox];
                end
                emit = 1'b1;
            end else begin
                held_back++;
            end
            win_cols[0] = win_cols[3];
            win_cols[1] = win_cols[4];
            win_cols[2] = win_cols[5];
            win_cols[3] = cur[0];
            win_cols[4] = cur[1];
            win_cols[5] = cur[2];
            line_top[x] = line_mid[x];
            line_mid[x] = pix;
            x++;
            if (x >= w) begin
                x = 0;
                y++;
                if (y >= h) y = 0;
            end
            pos_col = x;
            pos_row = y;
        end
        if (emit) begin
            res.out_red   = res_pix[23:16];
            res.out_green = res_pix[15:8];
            res.out_blue  = res_pix[7:0];
            res.frame_end = (j == total - 1);
            expected_pixels.push_back(res);
        end
    endtask

    // sender: hold a stalled request, otherwise idle or offer the next one
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_valid && !blk_stall) blur_predict(in_req);
            if (!in_valid || !blk_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (!calm && $urandom_range(5) == 0) begin
                    send_gap <= int'($urandom_range(9));
                    in_valid <= 1'b0;
                end else if (stream_reqs.size() != 0) begin
                    in_req   <= stream_reqs.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each taken output pixel, then pick the next stall
    always @(posedge i_clk) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else begin
            if (res_valid && !res_stall) begin
                if (expected_pixels.size() == 0) begin
                    $error("output pixel with none expected: %h", res_data);
                    bad_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (res_data.out_red !== want.out_red) begin
                        $error("out_red: expected %0d, actual %0d", want.out_red,
                               res_data.out_red);
                        bad_count++;
                    end
                    if (res_data.out_green !== want.out_green) begin
                        $error("out_green: expected %0d, actual %0d", want.out_green,
                               res_data.out_green);
                        bad_count++;
                    end
                    if (res_data.out_blue !== want.out_blue) begin
                        $error("out_blue: expected %0d, actual %0d", want.out_blue,
                               res_data.out_blue);
                        bad_count++;
                    end
                    if (res_data.frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0d, actual %0d", want.frame_end,
                               res_data.frame_end);
                        bad_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                res_stall <= 1'b1;
            end else if (hold_go && !hold_done) begin
                // one long back-pressure stretch to fill the pipe
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                res_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap  <= recv_gap - 1;
                res_stall <= 1'b1;
            end else if (!calm && $urandom_range(5) == 0) begin
                recv_gap  <= int'($urandom_range(9));
                res_stall <= 1'b1;
            end else begin
                res_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("box_blur_3x3_rgb_core_tb failed");
            $finish;
        end
    end

    // idle: nothing queued, nothing offered, nothing owed
    task automatic wait_idle();
        int quiet;
        quiet = 0;
        while (quiet < 8) begin
            @(posedge i_clk);
            if (stream_reqs.size() == 0 && !in_valid && expected_pixels.size() == 0)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    task automatic write_cfg(input logic [bb3_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bb3_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == bb3_pkg::CFG_IMAGE_WIDTH)
            cfg_width = value[bb3_pkg::WIDTH_W-1:0];
        else
            cfg_height = value[bb3_pkg::HEIGHT_W-1:0];
        // any write restarts the frame
        pos_col   = 0;
        pos_row   = 0;
        held_back = 0;
    endtask

    task automatic set_frame(input logic [bb3_pkg::CFG_DATA_W-1:0] width_data,
                             input logic [bb3_pkg::CFG_DATA_W-1:0] height_data);
        wait_idle();
        write_cfg(bb3_pkg::CFG_IMAGE_WIDTH, width_data);
        write_cfg(bb3_pkg::CFG_IMAGE_HEIGHT, height_data);
        frame_w = eff_width(width_data[bb3_pkg::WIDTH_W-1:0]);
        frame_h = (height_data == '0) ? 1 : 32'(height_data);
        gen_pos = 0;
    endtask

    task automatic add_pixel(input logic [23:0] rgb);
        stream_reqs.push_back(bb3_pkg::t_in_req'({bb3_pkg::MODE_PIXEL, rgb}));
    endtask

    task automatic add_flush();
        stream_reqs.push_back(bb3_pkg::t_in_req'({bb3_pkg::MODE_FLUSH, 24'($urandom)}));
    endtask

    // n raster pixels, with the odd stray flush mixed in when noisy
    task automatic add_pixels(input int unsigned n, input bit noisy);
        repeat (n) begin
            if (noisy && $urandom_range(19) == 0) add_flush();
            add_pixel(24'($urandom));
        end
        gen_pos = (gen_pos + n) % (frame_w * frame_h);
    endtask

    initial begin
        int unsigned rand_count, remaining, n, w_pick, h_pick;
        logic [bb3_pkg::CFG_DATA_W-1:0] w_data;

        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;

        // smallest frame with an interior pixel
        set_frame(16'd3, 16'd3);
        add_flush();                    // nothing held back yet
        add_pixel(24'hFFFFFF);
        add_pixel(24'h000000);
        add_pixel(24'hFFFFFF);
        add_pixel(24'h00FF00);
        add_flush();                    // mid-frame, ignored
        add_pixel(24'hFFFFFF);
        add_pixel(24'hFF0000);
        add_pixel(24'h0000FF);
        add_pixel(24'hFFFFFF);
        add_pixel(24'hFFFFFF);
        repeat (4) add_flush();         // drain, last one ends the frame
        add_flush();                    // drained already

        // zero width and height act as a 1x1 frame; upper data bits are dropped
        set_frame(16'hF800, 16'h0000);
        add_pixel(24'h123456);
        add_flush();
        add_flush();
        add_pixel(24'hABCDEF);
        add_pixel(24'h654321);          // new frame drops the held-back pixel
        add_flush();

        // tallest frame, one pixel wide
        set_frame(16'd1, 16'hFFFF);
        add_pixels(6, 1'b0);

        // random part opens with a long output hold-off on a busy stream
        set_frame(16'd4, 16'd5);
        hold_go = 1'b1;
        rand_count = 0;
        repeat (3) begin
            add_pixels(frame_w * frame_h, 1'b0);
            repeat (frame_w + 1) add_flush();
            rand_count += frame_w * frame_h + frame_w + 1;
        end

        while (rand_count < 500) begin
            if (rand_count >= 380) calm = 1'b1;
            case ($urandom_range(9))
                0:       w_pick = 0;
                1, 2:    w_pick = $urandom_range(24, 9);
                default: w_pick = $urandom_range(8, 1);
            endcase
            h_pick = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
            w_data = bb3_pkg::CFG_DATA_W'(w_pick);
            if ($urandom_range(3) == 0)
                w_data[bb3_pkg::CFG_DATA_W-1:bb3_pkg::WIDTH_W] = 5'($urandom);
            set_frame(w_data, bb3_pkg::CFG_DATA_W'(h_pick));
            repeat ($urandom_range(3, 1)) begin
                remaining = frame_w * frame_h - gen_pos;
                // mostly whole frames; now and then a frame cut short
                if (remaining > 1 && $urandom_range(4) == 0)
                    n = $urandom_range(remaining - 1, 1);
                else
                    n = remaining;
                add_pixels(n, 1'b1);
                rand_count += n;
                if (gen_pos == 0) begin
                    n = ($urandom_range(5) == 0) ? $urandom_range(frame_w + 3) : frame_w + 1;
                    repeat (n) add_flush();
                    rand_count += n;
                end
            end
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (bad_count == 0 && expected_pixels.size() == 0)
            $display("box_blur_3x3_rgb_core_tb passed");
        else
            $display("box_blur_3x3_rgb_core_tb failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/bb3_pkg.sv
hdl/bb3_mean_stage.sv
hdl/box_blur_3x3_rgb_core.sv
tb/sv/box_blur_3x3_rgb_core_tb.sv
